// ----- src/dxt_pkg.sv -----
// ----------------------------------------------------------------------------
// dxt_pkg
// Shared types, format codes and arithmetic helpers for the block decoder.
// ----------------------------------------------------------------------------
package dxt_pkg;

  // block format codes, code 3 decodes as dxt1
  typedef enum logic [1:0] {
    FMT_DXT1 = 2'd0,
    FMT_DXT3 = 2'd1,
    FMT_DXT5 = 2'd2
  } dxt_fmt_e;

  // four 8-bit palette entries of one colour channel
  typedef logic [3:0][7:0] dxt_pal_t;
  // eight-entry interpolated alpha table
  typedef logic [7:0][7:0] dxt_atab_t;

  // reciprocal multipliers, exact over the ranges used here
  localparam logic [9:0]  Div3Mul   = 10'd683;   // x <= 767
  localparam int          Div3Shift = 11;
  localparam logic [11:0] Div5Mul   = 12'd3277;  // x <= 1275
  localparam logic [11:0] Div7Mul   = 12'd2341;  // x <= 1785
  localparam int          Div57Shift = 14;

  // 5-bit endpoint to 8 bits
  function automatic logic [7:0] expand5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  // 6-bit endpoint to 8 bits
  function automatic logic [7:0] expand6(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  // truncating divide by three
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [19:0] p;
    p = {10'd0, x} * {10'd0, Div3Mul};
    return p[Div3Shift +: 8];
  endfunction

  // truncating divide by five
  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [22:0] p;
    p = {12'd0, x} * {11'd0, Div5Mul};
    return p[Div57Shift +: 8];
  endfunction

  // truncating divide by seven
  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [22:0] p;
    p = {12'd0, x} * {11'd0, Div7Mul};
    return p[Div57Shift +: 8];
  endfunction

endpackage

// ----- src/dxt_texture_block_decoder.sv -----
// ----------------------------------------------------------------------------
// dxt_texture_block_decoder
// Decodes one compressed 4x4 block (dxt1, dxt3 or dxt5) into sixteen BGRA
// pixels with pixel coordinates.
// ----------------------------------------------------------------------------
// channel   dir  fields
// s_axis    in   tdata: first_word, second_word, block_x, block_y
// m_axis    out  tdata: pixel_x, pixel_y, blue, green, red, alpha; tlast
// cfg       in   block_format (2 bits), written when cfg_we_i is high
//
// The output stream gives one pixel per cycle while m_axis_tready is high.
// A request passes the sum stage, then the load of the pixel buffer. The
// next block is accepted and its sums are formed while the current one
// streams, so blocks follow without gaps.
// Reset clears block_format to dxt1 and empties both stages.
// A stall on m_axis holds the current pixel and backs up into s_axis.
// ----------------------------------------------------------------------------
module dxt_texture_block_decoder
  import dxt_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // first_word[63:0], second_word[127:64], block_x[141:128],
  // block_y[155:142], zero fill[159:156]
  input  logic [159:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pixel_x[15:0], pixel_y[31:16], blue[39:32], green[47:40], red[55:48],
  // alpha[63:56]
  output logic [63:0]  m_axis_tdata,
  output logic         m_axis_tlast   // last_pixel
);

  logic [1:0]  block_format_q;
  logic        accept, load, ser_free;
  logic [63:0] first_word, second_word, cw;
  logic [15:0] c0, c1;

  logic        s1_valid_q;
  logic        s1_cgt_q;
  logic [31:0] s1_cidx_q;
  logic [63:0] s1_aw_q;
  logic [1:0]  s1_fmt_q;
  logic [13:0] s1_bx_q, s1_by_q;

  dxt_pal_t    pal_b, pal_g, pal_r;
  dxt_atab_t   tab;

  // format register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_format_q <= FMT_DXT1;
    end else if (cfg_we_i) begin
      block_format_q <= cfg_wdata_i;
    end
  end

  // stage handshake
  assign load          = s1_valid_q && ser_free;
  assign s_axis_tready = !s1_valid_q || load;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // colour half selection
  assign first_word  = s_axis_tdata[63:0];
  assign second_word = s_axis_tdata[127:64];
  assign cw = (block_format_q == FMT_DXT3 || block_format_q == FMT_DXT5) ?
              second_word : first_word;
  assign c0 = cw[15:0];
  assign c1 = cw[31:16];

  // sum stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (load) begin
      s1_valid_q <= 1'b0;
    end
  end

  // sum stage payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cgt_q  <= (c0 > c1);
      s1_cidx_q <= cw[63:32];
      s1_aw_q   <= first_word;
      s1_fmt_q  <= block_format_q;
      s1_bx_q   <= s_axis_tdata[141:128];
      s1_by_q   <= s_axis_tdata[155:142];
    end
  end

  // colour lanes
  dxt_colour_lane u_lane_b (
    .clk_i (clk_i),
    .en_i  (accept),
    .e0_i  (expand5(c0[4:0])),
    .e1_i  (expand5(c1[4:0])),
    .gt_i  (s1_cgt_q),
    .pal_o (pal_b)
  );

  dxt_colour_lane u_lane_g (
    .clk_i (clk_i),
    .en_i  (accept),
    .e0_i  (expand6(c0[10:5])),
    .e1_i  (expand6(c1[10:5])),
    .gt_i  (s1_cgt_q),
    .pal_o (pal_g)
  );

  dxt_colour_lane u_lane_r (
    .clk_i (clk_i),
    .en_i  (accept),
    .e0_i  (expand5(c0[15:11])),
    .e1_i  (expand5(c1[15:11])),
    .gt_i  (s1_cgt_q),
    .pal_o (pal_r)
  );

  // alpha table lanes
  dxt_alpha_table u_alpha (
    .clk_i (clk_i),
    .en_i  (accept),
    .a0_i  (first_word[7:0]),
    .a1_i  (first_word[15:8]),
    .tab_o (tab)
  );

  // merge and stream out
  dxt_pixel_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .pal_b_i       (pal_b),
    .pal_g_i       (pal_g),
    .pal_r_i       (pal_r),
    .cgt_i         (s1_cgt_q),
    .tab_i         (tab),
    .cidx_i        (s1_cidx_q),
    .aw_i          (s1_aw_q),
    .fmt_i         (s1_fmt_q),
    .bx_i          (s1_bx_q),
    .by_i          (s1_by_q),
    .free_o        (ser_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ----- src/dxt_colour_lane.sv -----
// ----------------------------------------------------------------------------
// dxt_colour_lane
// One colour channel: registers the endpoint sums, then builds the four
// palette entries for that channel.
// ----------------------------------------------------------------------------
module dxt_colour_lane
  import dxt_pkg::*;
(
  input  logic       clk_i,
  input  logic       en_i,
  input  logic [7:0] e0_i,
  input  logic [7:0] e1_i,
  input  logic       gt_i,    // c0 > c1, from the registered stage
  output dxt_pal_t   pal_o
);

  logic [7:0] e0_q, e1_q;
  logic [9:0] s01_q, s10_q;
  logic [8:0] sh_q;

  // endpoint sums
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e0_q  <= e0_i;
      e1_q  <= e1_i;
      s01_q <= {1'b0, e0_i, 1'b0} + {2'd0, e1_i};
      s10_q <= {2'd0, e0_i} + {1'b0, e1_i, 1'b0};
      sh_q  <= {1'b0, e0_i} + {1'b0, e1_i};
    end
  end

  // palette entries
  always_comb begin
    pal_o[0] = e0_q;
    pal_o[1] = e1_q;
    if (gt_i) begin
      pal_o[2] = div3(s01_q);
      pal_o[3] = div3(s10_q);
    end else begin
      pal_o[2] = sh_q[8:1];
      pal_o[3] = 8'd0;
    end
  end

endmodule

// ----- src/dxt_alpha_table.sv -----
// ----------------------------------------------------------------------------
// dxt_alpha_table
// Interpolated alpha table: six weighting lanes register their sums, then each
// divides by seven, or lanes 1-4 by five and lanes 5 and 6 give 0 and 255.
// ----------------------------------------------------------------------------
module dxt_alpha_table
  import dxt_pkg::*;
(
  input  logic       clk_i,
  input  logic       en_i,
  input  logic [7:0] a0_i,
  input  logic [7:0] a1_i,
  output dxt_atab_t  tab_o
);

  logic [7:0]  a0_q, a1_q;
  logic        agt_q;
  logic [10:0] sum7_q [6];
  logic [10:0] sum5_q [4];

  // endpoints and mode flag
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a0_q  <= a0_i;
      a1_q  <= a1_i;
      agt_q <= (a0_i > a1_i);
    end
  end

  assign tab_o[0] = a0_q;
  assign tab_o[1] = a1_q;

  // one lane per interpolated entry
  for (genvar k = 1; k <= 6; k++) begin : g_lane
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sum7_q[k-1] <= 11'(7 - k) * {3'd0, a0_i} + 11'(k) * {3'd0, a1_i};
      end
    end

    if (k <= 4) begin : g_five
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          sum5_q[k-1] <= 11'(5 - k) * {3'd0, a0_i} + 11'(k) * {3'd0, a1_i};
        end
      end
      assign tab_o[k+1] = agt_q ? div7(sum7_q[k-1]) : div5(sum5_q[k-1]);
    end else if (k == 5) begin : g_zero
      assign tab_o[k+1] = agt_q ? div7(sum7_q[k-1]) : 8'd0;
    end else begin : g_full
      assign tab_o[k+1] = agt_q ? div7(sum7_q[k-1]) : 8'd255;
    end
  end

endmodule

// ----- src/dxt_pixel_merge.sv -----
// ----------------------------------------------------------------------------
// dxt_pixel_merge
// Merges the colour lanes and the alpha table into sixteen pixels and
// streams them out one per cycle, when m_axis is ready, in row-major order.
// ----------------------------------------------------------------------------
module dxt_pixel_merge
  import dxt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  dxt_pal_t    pal_b_i,
  input  dxt_pal_t    pal_g_i,
  input  dxt_pal_t    pal_r_i,
  input  logic        cgt_i,
  input  dxt_atab_t   tab_i,
  input  logic [31:0] cidx_i,
  input  logic [63:0] aw_i,
  input  logic [1:0]  fmt_i,
  input  logic [13:0] bx_i,
  input  logic [13:0] by_i,
  output logic        free_o,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pixel_x[15:0], pixel_y[31:16], blue[39:32], green[47:40], red[55:48],
  // alpha[63:56]
  output logic [63:0] m_axis_tdata,
  output logic        m_axis_tlast   // last_pixel
);

  logic        valid_q;
  logic [3:0]  cnt_q;
  dxt_pal_t    pal_b_q, pal_g_q, pal_r_q;
  dxt_atab_t   tab_q;
  logic        cgt_q;
  logic [31:0] cidx_q;
  logic [63:0] aw_q;
  logic [1:0]  fmt_q;
  logic [13:0] bx_q, by_q;

  logic        last;
  logic [1:0]  sel;
  logic [3:0]  nib;
  logic [5:0]  apos;
  logic [2:0]  aidx;
  logic [7:0]  alpha;

  assign last   = (cnt_q == 4'd15);
  assign free_o = !valid_q || (last && m_axis_tready);

  // beat counter and valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= 4'd0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      cnt_q   <= 4'd0;
    end else if (valid_q && m_axis_tready) begin
      if (last) begin
        valid_q <= 1'b0;
      end
      cnt_q <= cnt_q + 4'd1;
    end
  end

  // block payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pal_b_q <= pal_b_i;
      pal_g_q <= pal_g_i;
      pal_r_q <= pal_r_i;
      tab_q   <= tab_i;
      cgt_q   <= cgt_i;
      cidx_q  <= cidx_i;
      aw_q    <= aw_i;
      fmt_q   <= fmt_i;
      bx_q    <= bx_i;
      by_q    <= by_i;
    end
  end

  // per-pixel selection, 3-bit alpha index starts at bit 16 + 3 * pixel
  assign sel  = cidx_q[{cnt_q, 1'b0} +: 2];
  assign nib  = aw_q[{cnt_q, 2'b00} +: 4];
  assign apos = 6'd16 + {1'b0, cnt_q, 1'b0} + {2'b00, cnt_q};
  assign aidx = aw_q[apos +: 3];

  always_comb begin
    case (fmt_q)
      FMT_DXT3: alpha = {nib, nib};
      FMT_DXT5: alpha = tab_q[aidx];
      default:  alpha = (sel == 2'd3 && !cgt_q) ? 8'd0 : 8'd255;
    endcase
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tlast  = last;
  assign m_axis_tdata  = {alpha, pal_r_q[sel], pal_g_q[sel], pal_b_q[sel],
                          by_q, cnt_q[3:2], bx_q, cnt_q[1:0]};

endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the dxt block decoder. Blocks go in on s_axis, each
// is decoded here in parallel to sixteen expected BGRA pixels, and every
// pixel taken from m_axis is compared field by field against the oldest one
// still waiting. Runs a directed set per format code, then random blocks
// under several idle and stall patterns, a long output hold-off and a drain
// pause.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dxt_pkg::*;

  // spare format code, the decoder treats it as dxt1
  localparam logic [1:0] FMT_SPARE = 2'd3;

  localparam int ClkHalf        = 5;
  localparam int StallLimit     = 4000;
  localparam int HoldCycles     = 150;
  localparam int DrainCycles    = 20;
  localparam int NumDirected    = 6;
  localparam int NumPhases      = 8;
  localparam int RandomPerPhase = 14;

  // directed blocks: colour half, alpha half and block coordinates
  localparam logic [63:0] DirColour [NumDirected] = '{
    64'h0000_0000_0000_0000,
    64'hFFFF_FFFF_FFFF_FFFF,
    64'hE4E4_E4E4_0000_FFFF,  // c0 above c1, all four indices
    64'hE4E4_E4E4_FFFF_0000,  // c0 below c1, transparent black entry
    64'h1B1B_1B1B_A5A5_A5A5,  // equal endpoints
    64'h39C6_0F0F_7BEF_8410
  };
  localparam logic [63:0] DirAlpha [NumDirected] = '{
    64'h0000_0000_0000_0000,  // equal alpha endpoints at zero
    64'hFFFF_FFFF_FFFF_FFFF,  // equal alpha endpoints at full
    64'hFEDC_BA98_7654_3210,  // every explicit nibble
    64'hFAC6_88FA_C688_FF00,  // a0 below a1, every 3-bit index
    64'hFAC6_88FA_C688_00FF,  // a0 above a1, every 3-bit index
    64'h0123_4567_89AB_CDEF
  };
  localparam logic [13:0] DirBlockX [NumDirected] = '{
    14'd0, 14'd16383, 14'd1, 14'd16383, 14'd5461, 14'd10922
  };
  localparam logic [13:0] DirBlockY [NumDirected] = '{
    14'd0, 14'd16383, 14'd16383, 14'd0, 14'd10922, 14'd42
  };
  localparam logic [1:0] DirFmt [4] = '{FMT_DXT1, FMT_DXT3, FMT_DXT5, FMT_SPARE};

  // format and idle pattern for each random phase
  localparam logic [1:0] PhaseFmt [NumPhases] = '{
    FMT_DXT5, FMT_DXT1, FMT_DXT3, FMT_SPARE, FMT_DXT5, FMT_DXT3, FMT_DXT1, FMT_DXT5
  };
  localparam int SendPct [4] = '{0, 59, 0, 38};
  localparam int RecvPct [4] = '{0, 0, 59, 38};
  localparam int HoldPhase  = 4;
  localparam int PausePhase = 5;

  typedef struct packed {
    logic [15:0] px;
    logic [15:0] py;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [7:0]  alpha;
    logic        last;
  } pixel_t;

  // --------------------------------------------------------------------------
  // expected pixel store and block decode
  // --------------------------------------------------------------------------
  class pixel_scoreboard;
    pixel_t pixel_q[$];
    int     errors;

    function new();
      errors = 0;
    endfunction

    function int pending();
      return pixel_q.size();
    endfunction

    task report(input string what);
      $display("ERROR: %s", what);
      errors++;
    endtask

    // one channel of an rgb565 endpoint widened to 8 bits
    function int endpoint_channel(input int c, input int ch);
      int bits, shift, v;
      bits  = (ch == 1) ? 6 : 5;
      shift = (ch == 0) ? 0 : (ch == 1) ? 5 : 11;
      v     = (c >> shift) & ((1 << bits) - 1);
      return (v << (8 - bits)) | (v >> (2 * bits - 8));
    endfunction

    // decode a request into its sixteen pixels
    function void note_block(input logic [1:0] fmt, input logic [63:0] w0,
                             input logic [63:0] w1, input logic [13:0] bx,
                             input logic [13:0] by);
      logic [63:0] cw;
      int          c0, c1, e0, e1, a0, a1, ch, k, i, sel, a;
      int          pal [4][4];
      int          tab [8];
      pixel_t      pix;
      cw = (fmt == FMT_DXT3 || fmt == FMT_DXT5) ? w1 : w0;
      c0 = cw[15:0];
      c1 = cw[31:16];
      // colour palette, four entries of b, g, r, a
      for (ch = 0; ch < 3; ch++) begin
        e0 = endpoint_channel(c0, ch);
        e1 = endpoint_channel(c1, ch);
        pal[0][ch] = e0;
        pal[1][ch] = e1;
        if (c0 > c1) begin
          pal[2][ch] = (2 * e0 + e1) / 3;
          pal[3][ch] = (e0 + 2 * e1) / 3;
        end else begin
          pal[2][ch] = (e0 + e1) / 2;
          pal[3][ch] = 0;
        end
      end
      for (k = 0; k < 4; k++) pal[k][3] = 255;
      if (c0 <= c1) pal[3][3] = 0;
      // interpolated alpha table
      a0 = w0[7:0];
      a1 = w0[15:8];
      tab[0] = a0;
      tab[1] = a1;
      if (a0 > a1) begin
        for (k = 1; k <= 6; k++) tab[1 + k] = ((7 - k) * a0 + k * a1) / 7;
      end else begin
        for (k = 1; k <= 4; k++) tab[1 + k] = ((5 - k) * a0 + k * a1) / 5;
        tab[6] = 0;
        tab[7] = 255;
      end
      // pixels in row-major order
      for (i = 0; i < 16; i++) begin
        sel = cw[32 + 2 * i +: 2];
        if (fmt == FMT_DXT3) a = int'(w0[4 * i +: 4]) * 17;
        else if (fmt == FMT_DXT5) a = tab[w0[16 + 3 * i +: 3]];
        else a = pal[sel][3];
        pix.px    = {bx, 2'b00} + 16'(i % 4);
        pix.py    = {by, 2'b00} + 16'(i / 4);
        pix.blue  = 8'(pal[sel][0]);
        pix.green = 8'(pal[sel][1]);
        pix.red   = 8'(pal[sel][2]);
        pix.alpha = 8'(a);
        pix.last  = (i == 15);
        pixel_q.push_back(pix);
      end
    endfunction

    task check_field(input string name, input pixel_t want, input int got,
                     input int exp_val);
      if (got != exp_val)
        report($sformatf("%s at (%0d,%0d): got %0d expected %0d",
                         name, want.px, want.py, got, exp_val));
    endtask

    // compare one output pixel with the oldest expectation
    task check_pixel(input logic [63:0] data, input logic last);
      pixel_t want;
      if (pixel_q.size() == 0) begin
        report($sformatf("pixel %h with no block pending", data));
        return;
      end
      want = pixel_q.pop_front();
      check_field("pixel_x", want, data[15:0], want.px);
      check_field("pixel_y", want, data[31:16], want.py);
      check_field("blue", want, data[39:32], want.blue);
      check_field("green", want, data[47:40], want.green);
      check_field("red", want, data[55:48], want.red);
      check_field("alpha", want, data[63:56], want.alpha);
      check_field("last_pixel", want, last, want.last);
    endtask
  endclass

  // --------------------------------------------------------------------------
  // signals and block under test
  // --------------------------------------------------------------------------
  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         cfg_we_i      = 1'b0;
  logic [1:0]   cfg_wdata_i   = FMT_DXT1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [159:0] s_axis_tdata  = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [63:0]  m_axis_tdata;
  logic         m_axis_tlast;

  pixel_scoreboard sb = new();
  logic [1:0]      cur_fmt     = FMT_DXT1;
  int              send_pct    = 0;
  int              recv_pct    = 0;
  bit              hold_req    = 1'b0;
  int              hold_left   = 0;
  int              idle_cycles = 0;

  dxt_texture_block_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #ClkHalf clk_i = ~clk_i;

  // pixel side: check accepted pixels, then drive ready
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) sb.check_pixel(m_axis_tdata, m_axis_tlast);
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_pct);
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus tasks
  // --------------------------------------------------------------------------
  // stop offering and wait until every expected pixel is out
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic set_format(input logic [1:0] fmt);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= fmt;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_fmt = fmt;
  endtask

  // offer one request, with an optional idle gap ahead of it
  task automatic send_block(input logic [63:0] w0, input logic [63:0] w1,
                            input logic [13:0] bx, input logic [13:0] by);
    if ($urandom_range(99) < send_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'd0, by, bx, w1, w0};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_block(cur_fmt, w0, w1, bx, by);
  endtask

  // random block, biased toward equal endpoints and edge coordinates
  task automatic send_random();
    logic [63:0] w0, w1;
    logic [13:0] bx, by;
    w0 = {$urandom, $urandom};
    w1 = {$urandom, $urandom};
    case ($urandom_range(7))
      0: begin
        if (cur_fmt == FMT_DXT3 || cur_fmt == FMT_DXT5) w1[31:16] = w1[15:0];
        else w0[31:16] = w0[15:0];
      end
      1: w0[15:8] = w0[7:0];
      default: ;
    endcase
    bx = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 14'h3FFF : 14'h0000)
                                  : 14'($urandom);
    by = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 14'h3FFF : 14'h0000)
                                  : 14'($urandom);
    send_block(w0, w1, bx, by);
  endtask

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin
    int f, k, p;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed blocks under every format code
    for (f = 0; f < 4; f++) begin
      set_format(DirFmt[f]);
      for (k = 0; k < NumDirected; k++) begin
        if (cur_fmt == FMT_DXT3 || cur_fmt == FMT_DXT5)
          send_block(DirAlpha[k], DirColour[k], DirBlockX[k], DirBlockY[k]);
        else
          send_block(DirColour[k], DirAlpha[k], DirBlockX[k], DirBlockY[k]);
      end
    end

    // random phases with changing format and idle pattern
    for (p = 0; p < NumPhases; p++) begin
      set_format(PhaseFmt[p]);
      send_pct = SendPct[p % 4];
      recv_pct = RecvPct[p % 4];
      if (p == HoldPhase) hold_req = 1'b1;
      for (k = 0; k < RandomPerPhase; k++) begin
        if (p == PausePhase && k == RandomPerPhase / 2) wait_drained();
        send_random();
      end
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/dxt_pkg.sv
src/dxt_colour_lane.sv
src/dxt_alpha_table.sv
src/dxt_pixel_merge.sv
src/dxt_texture_block_decoder.sv
tb/sv/tb.sv
